/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue store
// Operation codes, result status codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_POP_BACK   = 3'd1,
    FUNC_PUSH_FRONT = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_SHOW       = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    push_back;      // write at back slot, count + 1
    logic    push_front;     // write at new front slot, front - 1, count + 1
    logic    pop_back;       // read back slot, count - 1
    logic    pop_front;      // read front slot, front + 1, count - 1
    logic    rd_show_first;  // read offset 0, walk index cleared
    logic    rd_show_next;   // read offset index + 1, walk index advanced
    logic    ld_zero;        // result register: item 0, given status, last
    logic    ld_mem;         // result register: read data, status ok
    logic    ld_last;
    status_e ld_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic show_last;  // walk index points at the final stored entry
  } sts_t;

endpackage

/* rtl/deq_in_if.sv */
// ----------------------------------------------------------------------------
// deq_in_if: operation channel
// Valid/ready channel carrying one queue operation and its push value.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [deq_pkg::FUNC_W-1:0]   func;
  logic signed [deq_pkg::DATA_W-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

/* rtl/deq_out_if.sv */
// ----------------------------------------------------------------------------
// deq_out_if: result channel
// Valid/ready channel carrying one result: value, status and last marker.
// ----------------------------------------------------------------------------
interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   item;
  logic        [deq_pkg::STATUS_W-1:0] status;
  logic                                last;

  modport source (output valid, output item, output status, output last, input ready);
  modport sink   (input valid, input item, input status, input last, output ready);
endinterface

/* rtl/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl: queue operation sequencer
// Takes one operation at a time, issues pointer updates and memory reads,
// and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [deq_pkg::FUNC_W-1:0]  func_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic                        out_last_i,
  input  deq_pkg::sts_t               sts_i,
  output deq_pkg::cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   showing_q, showing_d;
  logic   in_fire, out_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    cmd_o     = '0;
    cmd_o.ld_status = deq_pkg::ST_OK;
    state_d   = state_q;
    showing_d = showing_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (func_i)
            deq_pkg::FUNC_PUSH_BACK, deq_pkg::FUNC_PUSH_FRONT: begin
              cmd_o.ld_zero   = 1'b1;
              cmd_o.ld_last   = 1'b1;
              state_d         = S_OUT;
              if (sts_i.full) begin
                cmd_o.ld_status = deq_pkg::ST_FULL;
              end else begin
                cmd_o.push_back  = (func_i == deq_pkg::FUNC_PUSH_BACK);
                cmd_o.push_front = (func_i == deq_pkg::FUNC_PUSH_FRONT);
              end
            end
            deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_SHOW: begin
              if (sts_i.empty) begin
                cmd_o.ld_zero   = 1'b1;
                cmd_o.ld_last   = 1'b1;
                cmd_o.ld_status = deq_pkg::ST_EMPTY;
                state_d         = S_OUT;
              end else begin
                cmd_o.pop_back      = (func_i == deq_pkg::FUNC_POP_BACK);
                cmd_o.pop_front     = (func_i == deq_pkg::FUNC_POP_FRONT);
                cmd_o.rd_show_first = (func_i == deq_pkg::FUNC_SHOW);
                showing_d           = (func_i == deq_pkg::FUNC_SHOW);
                state_d             = S_READ;
              end
            end
            default: ;  // unused codes: taken, no result
          endcase
        end
      end
      S_READ: begin
        cmd_o.ld_mem  = 1'b1;
        cmd_o.ld_last = showing_q ? sts_i.show_last : 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          if (out_last_i) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_show_next = 1'b1;
            state_d            = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      showing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      showing_q <= showing_d;
    end
  end

endmodule

/* rtl/deq_dp.sv */
// ----------------------------------------------------------------------------
// deq_dp: queue datapath
// Ring memory, front pointer, count, show walk index and result register.
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [deq_pkg::DATA_W-1:0]   value_i,
  input  deq_pkg::cmd_t                       cmd_i,
  output deq_pkg::sts_t                       sts_o,
  output logic signed [deq_pkg::DATA_W-1:0]   item_o,
  output logic        [deq_pkg::STATUS_W-1:0] status_o,
  output logic                                last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [deq_pkg::DATA_W-1:0] rd_data_q;

  logic signed [deq_pkg::DATA_W-1:0]   item_q;
  logic        [deq_pkg::STATUS_W-1:0] status_q;
  logic                                last_q;

  logic [IDX_W-1:0] back_slot, popb_slot, pushf_slot, popf_next, show_slot;
  logic [IDX_W-1:0] cnt_lo, cnt_m1, show_off;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             we, re;

  // (base + offset) mod DEPTH with both operands below DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign cnt_lo   = count_q[IDX_W-1:0];
  assign cnt_m1   = IDX_W'(count_q - CNT_W'(1));
  assign show_off = cmd_i.rd_show_first ? '0 : idx_q + IDX_W'(1);

  assign back_slot  = wrap_add(front_q, cnt_lo);
  assign popb_slot  = wrap_add(front_q, cnt_m1);
  assign show_slot  = wrap_add(front_q, show_off);
  assign pushf_slot = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
  assign popf_next  = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);

  assign we      = cmd_i.push_back || cmd_i.push_front;
  assign wr_addr = cmd_i.push_front ? pushf_slot : back_slot;
  assign re      = cmd_i.pop_back || cmd_i.pop_front
                   || cmd_i.rd_show_first || cmd_i.rd_show_next;

  always_comb begin
    priority if (cmd_i.pop_back) begin
      rd_addr = popb_slot;
    end else if (cmd_i.pop_front) begin
      rd_addr = front_q;
    end else begin
      rd_addr = show_slot;
    end
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.push_front) front_d = pushf_slot;
    if (cmd_i.pop_front)  front_d = popf_next;
    if (we)                                 count_d = count_q + CNT_W'(1);
    if (cmd_i.pop_back || cmd_i.pop_front)  count_d = count_q - CNT_W'(1);
    if (cmd_i.rd_show_first || cmd_i.rd_show_next) idx_d = show_off;
  end

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.show_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= value_i;
    end
    if (re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_zero) begin
      item_q   <= '0;
      status_q <= cmd_i.ld_status;
      last_q   <= cmd_i.ld_last;
    end else if (cmd_i.ld_mem) begin
      item_q   <= rd_data_q;
      status_q <= deq_pkg::ST_OK;
      last_q   <= cmd_i.ld_last;
    end
  end

  assign item_o   = item_q;
  assign status_o = status_q;
  assign last_o   = last_q;

endmodule

/* rtl/double_ended_queue_store_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_store_core: bounded double-ended queue of 32-bit values
// Push/pop at either end and a front-to-back show, on valid/ready channels.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An unused operation code is taken
// with no result and the next operation can be accepted on the following
// cycle. A push, or a pop or show on an empty queue, loads the one-entry
// result register directly. A pop reads the ring memory, whose read data is
// registered, and then loads that data into the result register; a show
// does so for each stored entry from front to back, reading the next entry
// only once the result before it is taken. A push to a full queue is dropped
// with status full; a pop or show on an empty queue returns one result with
// status empty. Every operation's final result carries last.
// No initialization pass is needed after reset.
module double_ended_queue_store_core #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_in_if.sink     in_i,
  deq_out_if.source  out_o
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .func_i      (in_i.func),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_last_i  (out_o.last),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (in_i.value),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .item_o   (out_o.item),
    .status_o (out_o.status),
    .last_o   (out_o.last)
  );

endmodule
